// ----- sv/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// shared types and constants for the subset-sum count and pick chain
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  // fixed field widths of the request and result channels
  localparam int MASK_BITS = 9;
  localparam int SUM_W     = 4;
  localparam int CNT_W     = 9;

  typedef logic [MASK_BITS-1:0] mask_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cnt_t CNT_ONE = cnt_t'(1);

  // control carried along the forward (table building) cells
  typedef struct packed {
    logic  vld;
    mask_t mask;
    sum_t  target;
  } fwd_ctl_t;

  // control carried along the backward (picking) cells
  typedef struct packed {
    logic  vld;
    logic  live;
    mask_t mask;
    cnt_t  count;
    sum_t  rem;
    mask_t chosen;
  } back_ctl_t;

endpackage

`default_nettype wire

// ----- sv/ssc_fwd_cell.sv -----
// ----------------------------------------------------------------------------
// ssc_fwd_cell
// one table row: adds item ITEM to the running count row of a request
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_fwd_cell #(
  parameter int NUM_ITEMS = 9,
  parameter int TCOLS     = 13,
  parameter int ITEM      = 1
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 adv,
  input  ssc_pkg::fwd_ctl_t                   ctl_i,
  input  ssc_pkg::cnt_t [TCOLS-1:0]           row_i,
  input  wire [NUM_ITEMS-1:0][TCOLS-1:0]      hist_i,
  output ssc_pkg::fwd_ctl_t                   ctl_o,
  output ssc_pkg::cnt_t [TCOLS-1:0]           row_o,
  output logic [NUM_ITEMS-1:0][TCOLS-1:0]     hist_o
);
  import ssc_pkg::*;

  fwd_ctl_t                         ctl_r;
  cnt_t [TCOLS-1:0]                 row_r;
  cnt_t [TCOLS-1:0]                 row_nxt;
  logic [NUM_ITEMS-1:0][TCOLS-1:0]  hist_r;
  logic [NUM_ITEMS-1:0][TCOLS-1:0]  hist_nxt;
  logic [TCOLS-1:0]                 reach;
  logic                             use_item;

  // item joins when it has a mask bit, is set and fits under the target
  if (ITEM <= MASK_BITS) begin : g_use
    assign use_item = ctl_i.mask[ITEM-1] && (ctl_i.target >= sum_t'(ITEM));
  end else begin : g_nouse
    assign use_item = 1'b0;
  end

  for (genvar s = 0; s < TCOLS; s++) begin : g_col
    if (ITEM <= MASK_BITS && s == ITEM) begin : g_single
      assign row_nxt[s] = row_i[s] + (use_item ? CNT_ONE : '0);
    end else if (ITEM <= MASK_BITS && s > ITEM) begin : g_add
      assign row_nxt[s] = row_i[s] + (use_item ? row_i[s-ITEM] : '0);
    end else begin : g_keep
      assign row_nxt[s] = row_i[s];
    end
    // sum zero is always reachable by the empty subset
    if (s == 0) begin : g_zero
      assign reach[s] = 1'b1;
    end else begin : g_nz
      assign reach[s] = (row_i[s] != '0);
    end
  end

  always_comb begin
    hist_nxt         = hist_i;
    hist_nxt[ITEM-1] = reach;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_r  <= row_nxt;
      hist_r <= hist_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign row_o  = row_r;
  assign hist_o = hist_r;

endmodule

`default_nettype wire

// ----- sv/ssc_back_cell.sv -----
// ----------------------------------------------------------------------------
// ssc_back_cell
// one backtrack step: takes item ITEM when the remaining sum stays reachable
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_back_cell #(
  parameter int NUM_ITEMS = 9,
  parameter int TCOLS     = 13,
  parameter int ITEM      = 1
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 adv,
  input  ssc_pkg::back_ctl_t                  ctl_i,
  input  wire [NUM_ITEMS-1:0][TCOLS-1:0]      hist_i,
  output ssc_pkg::back_ctl_t                  ctl_o,
  output logic [NUM_ITEMS-1:0][TCOLS-1:0]     hist_o
);
  import ssc_pkg::*;

  localparam int CW = $clog2(TCOLS);

  back_ctl_t                        ctl_r;
  back_ctl_t                        ctl_nxt;
  logic [NUM_ITEMS-1:0][TCOLS-1:0]  hist_r;
  logic                             take;
  sum_t                             diff;
  mask_t                            set_bit;

  // row ITEM beats row ITEM-1 at rem exactly when rem-ITEM is reachable
  // without this item
  if (ITEM <= MASK_BITS) begin : g_pick
    assign diff    = ctl_i.rem - sum_t'(ITEM);
    assign take    = ctl_i.live && ctl_i.mask[ITEM-1] &&
                     (ctl_i.rem >= sum_t'(ITEM)) && hist_i[ITEM-1][diff[CW-1:0]];
    assign set_bit = take ? (mask_t'(1) << (ITEM-1)) : '0;
  end else begin : g_nopick
    assign diff    = ctl_i.rem;
    assign take    = 1'b0;
    assign set_bit = '0;
  end

  always_comb begin
    ctl_nxt        = ctl_i;
    ctl_nxt.rem    = take ? diff : ctl_i.rem;
    ctl_nxt.chosen = ctl_i.chosen | set_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hist_r <= hist_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign hist_o = hist_r;

endmodule

`default_nettype wire

// ----- sv/subset_sum_count_and_pick.sv -----
// ----------------------------------------------------------------------------
// subset_sum_count_and_pick
// counts subsets of the available items that reach a target sum and picks
// the subset that uses the largest items first
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   in_       request    in_valid/in_stall  available_mask[9], target_sum[4]
//   out_      result     out_valid/out_stall subset_count[9], chosen_mask[9],
//                                           left_mask[9], found[1]
//
// one request per cycle sustained while the output is not stalled; each result
// passes through the chain of NUM_ITEMS forward cells, NUM_ITEMS backward
// cells and the output register
// reset clears only the valid bits of the chain, no memories to sweep
// a stalled output holding a valid result freezes the whole chain; in_stall is high exactly then
// ----------------------------------------------------------------------------
`default_nettype none

module subset_sum_count_and_pick #(
  parameter int NUM_ITEMS  = 9,
  parameter int MAX_TARGET = 12
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ssc_pkg::mask_t      in_available_mask,
  input  ssc_pkg::sum_t       in_target_sum,
  output logic                out_valid,
  input  wire                 out_stall,
  output ssc_pkg::cnt_t       out_subset_count,
  output ssc_pkg::mask_t      out_chosen_mask,
  output ssc_pkg::mask_t      out_left_mask,
  output logic                out_found
);
  import ssc_pkg::*;

  // the target field can never exceed its own range, so no column beyond it
  localparam int SUM_MAX = (1 << SUM_W) - 1;
  localparam int MAXT    = (MAX_TARGET < SUM_MAX) ? MAX_TARGET : SUM_MAX;
  localparam int TCOLS   = MAXT + 1;
  localparam int CW      = $clog2(TCOLS);

  logic adv;

  // forward chain: row k of the counting table after cell k
  fwd_ctl_t                         fctl  [0:NUM_ITEMS];
  cnt_t [TCOLS-1:0]                 frow  [0:NUM_ITEMS];
  logic [NUM_ITEMS-1:0][TCOLS-1:0]  fhist [0:NUM_ITEMS];

  // backward chain: items NUM_ITEMS down to 1
  back_ctl_t                        bctl  [0:NUM_ITEMS];
  logic [NUM_ITEMS-1:0][TCOLS-1:0]  bhist [0:NUM_ITEMS];

  logic  tgt_ok;
  cnt_t  cnt_sel;

  logic  out_valid_r;
  cnt_t  out_count_r;
  mask_t out_chosen_r;
  mask_t out_left_r;
  logic  out_found_r;
  logic  found_nxt;

  // the whole chain moves unless a finished result is held by the sink
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // row zero of the table: no non-empty subset yet
  assign fctl[0]  = '{vld: in_valid, mask: in_available_mask, target: in_target_sum};
  assign frow[0]  = '0;
  assign fhist[0] = '0;

  for (genvar k = 0; k < NUM_ITEMS; k++) begin : g_fwd
    ssc_fwd_cell #(
      .NUM_ITEMS (NUM_ITEMS),
      .TCOLS     (TCOLS),
      .ITEM      (k + 1)
    ) u_fwd (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (fctl[k]),
      .row_i  (frow[k]),
      .hist_i (fhist[k]),
      .ctl_o  (fctl[k+1]),
      .row_o  (frow[k+1]),
      .hist_o (fhist[k+1])
    );
  end

  // count at the target column; zero or out-of-table targets count nothing
  assign tgt_ok  = (fctl[NUM_ITEMS].target != '0) &&
                   (fctl[NUM_ITEMS].target <= sum_t'(MAXT));
  assign cnt_sel = tgt_ok ? frow[NUM_ITEMS][fctl[NUM_ITEMS].target[CW-1:0]] : '0;

  assign bctl[0]  = '{vld:    fctl[NUM_ITEMS].vld,
                      live:   (cnt_sel != '0),
                      mask:   fctl[NUM_ITEMS].mask,
                      count:  cnt_sel,
                      rem:    fctl[NUM_ITEMS].target,
                      chosen: '0};
  assign bhist[0] = fhist[NUM_ITEMS];

  for (genvar k = 0; k < NUM_ITEMS; k++) begin : g_back
    ssc_back_cell #(
      .NUM_ITEMS (NUM_ITEMS),
      .TCOLS     (TCOLS),
      .ITEM      (NUM_ITEMS - k)
    ) u_back (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (bctl[k]),
      .hist_i (bhist[k]),
      .ctl_o  (bctl[k+1]),
      .hist_o (bhist[k+1])
    );
  end

  // a pick that does not land on zero reports nothing
  assign found_nxt = bctl[NUM_ITEMS].live && (bctl[NUM_ITEMS].rem == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= bctl[NUM_ITEMS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_count_r  <= found_nxt ? bctl[NUM_ITEMS].count : '0;
      out_chosen_r <= found_nxt ? bctl[NUM_ITEMS].chosen : '0;
      out_left_r   <= found_nxt ? (bctl[NUM_ITEMS].mask & ~bctl[NUM_ITEMS].chosen) : '0;
      out_found_r  <= found_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_subset_count = out_count_r;
  assign out_chosen_mask  = out_chosen_r;
  assign out_left_mask    = out_left_r;
  assign out_found        = out_found_r;

endmodule

`default_nettype wire
